// ===== rtl/core/brhm_pkg.sv =====
`default_nettype none

package brhm_pkg;

  // Sizing of the map.
  localparam int MAP_ENTRIES      = 1024;
  localparam int BLOCKS_PER_RANGE = 128;
  localparam int REL_SLOTS        = 16;

  // Field widths.
  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int ID_W      = 32;
  localparam int KEY_W     = 3 * ID_W;
  localparam int COUNTER_W = 32;
  localparam int DIVISOR_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  // Derived widths and limits.
  localparam int SLOT_W    = (REL_SLOTS > 1) ? $clog2(REL_SLOTS) : 1;
  localparam int MAP_IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int ADDR_W    = SLOT_W + MAP_IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int STEP_W    = $clog2(COUNTER_W);
  localparam logic [ID_W:0] MAP_BLOCKS = (ID_W + 1)'(MAP_ENTRIES * BLOCKS_PER_RANGE);

  // Register reset values.
  localparam logic [ID_W-1:0]      FIRST_USER_REL_RST = ID_W'(16384);
  localparam logic [DIVISOR_W-1:0] COOL_DIVISOR_RST   = DIVISOR_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_USER_REL = 1'd0,
    CFG_COOL_DIVISOR   = 1'd1
  } cfg_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_WARM  = 3'd0,
    REQ_COOL  = 3'd1,
    REQ_DIV   = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_READ  = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SYSTEM     = 3'd1,
    ST_OUT_OF_MAP = 3'd2,
    ST_FULL       = 3'd3,
    ST_ABSENT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SWEEP,
    S_READ,
    S_UPDATE,
    S_DIV,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    pick;
    logic    alloc;
    logic    sweep_wr;
    logic    apply;
    logic    div_start;
    logic    div_wr;
    logic    emit;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic unused;
    logic system;
    logic clear;
    logic read;
    logic div;
    logic oom;
    logic hit;
    logic free;
    logic sweep_last;
    logic div_zero;
    logic div_done;
    logic out_free;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/brhm_ram.sv =====
`default_nettype none

module brhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/brhm_div.sv =====
`default_nettype none

module brhm_div (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic signed [brhm_pkg::COUNTER_W-1:0]  dividend_i,
  input  wire logic        [brhm_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                                        done_o,
  output logic signed      [brhm_pkg::COUNTER_W-1:0]  quotient_o
);
  import brhm_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]   rem_q, rem_d;
  logic [COUNTER_W-1:0]   quo_q, quo_d;
  logic [DIVISOR_W-1:0]   dvs_q, dvs_d;
  logic                   neg_q, neg_d;
  logic [DIVISOR_W:0]     shifted;
  logic                   ge;

  // One quotient bit per cycle on the magnitude; sign restored at the end.
  always_comb begin
    shifted = {rem_q, quo_q[COUNTER_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      neg_d  = dividend_i[COUNTER_W-1];
      quo_d  = dividend_i[COUNTER_W-1] ? COUNTER_W'(-dividend_i) : COUNTER_W'(dividend_i);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIVISOR_W'(shifted - {1'b0, dvs_q}) : shifted[DIVISOR_W-1:0];
      quo_d = {quo_q[COUNTER_W-2:0], ge};
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(COUNTER_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

`ifndef SYNTHESIS
  // The controller never restarts a division in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/brhm_dp.sv =====
`default_nettype none

module brhm_dp (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Configuration.
  input  wire logic                                   cfg_we_i,
  input  wire logic        [brhm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [brhm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Request payload.
  input  wire logic        [brhm_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       tablespace_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       database_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       relation_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       block_number_i,
  // Result channel.
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic             [brhm_pkg::STATUS_W-1:0]   status_o,
  output logic signed      [brhm_pkg::COUNTER_W-1:0]  counter_value_o,
  // Controller link.
  input  wire brhm_pkg::cmd_t                         cmd_i,
  output brhm_pkg::flags_t                            flags_o
);
  import brhm_pkg::*;

  localparam logic signed [COUNTER_W-1:0] CNT_MAX = {1'b0, {(COUNTER_W-1){1'b1}}};
  localparam logic signed [COUNTER_W-1:0] CNT_MIN = {1'b1, {(COUNTER_W-1){1'b0}}};

  logic [ID_W-1:0]              first_rel_q;
  logic [DIVISOR_W-1:0]         cool_div_q;

  logic [REQ_W-1:0]             req_q;
  logic [KEY_W-1:0]             key_q;
  logic [ID_W-1:0]              blk_q;

  logic [KEY_W-1:0]             slot_key_q [REL_SLOTS];
  logic [REL_SLOTS-1:0]         slot_valid_q;
  logic [REL_SLOTS-1:0]         hit_vec;
  logic [SLOT_W-1:0]            hit_slot, free_slot;
  logic [SLOT_W-1:0]            slot_q;
  logic [MAP_IDX_W-1:0]         sweep_cnt_q;
  logic [MAP_IDX_W-1:0]         range_idx;

  logic signed [COUNTER_W-1:0]  value_q;
  logic signed [COUNTER_W-1:0]  cur_val, upd_val, div_quot;
  logic                         div_done;

  logic                         out_valid_q;
  status_e                      out_status_q;
  logic signed [COUNTER_W-1:0]  out_value_q;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [COUNTER_W-1:0]         ram_wdata, ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_rel_q <= FIRST_USER_REL_RST;
      cool_div_q  <= COOL_DIVISOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FIRST_USER_REL: first_rel_q <= cfg_wdata_i[ID_W-1:0];
        CFG_COOL_DIVISOR:   cool_div_q  <= cfg_wdata_i[DIVISOR_W-1:0];
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      key_q <= {tablespace_id_i, database_id_i, relation_id_i};
      blk_q <= block_number_i;
    end
  end

  assign range_idx = MAP_IDX_W'(blk_q / BLOCKS_PER_RANGE);

  // Slot lookup: the lowest matching slot and the lowest free slot.
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = REL_SLOTS - 1; i >= 0; i--) begin
      hit_vec[i] = slot_valid_q[i] && (slot_key_q[i] == key_q);
      if (hit_vec[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (!slot_valid_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Slot table: keys are only compared where the valid bit is set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (cmd_i.alloc) begin
      slot_valid_q[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      slot_key_q[free_slot] <= key_q;
    end
  end

  // Working slot and the zeroing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      sweep_cnt_q <= '0;
    end else if (cmd_i.pick) begin
      slot_q      <= (|hit_vec) ? hit_slot : free_slot;
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep_wr) begin
      sweep_cnt_q <= sweep_cnt_q + MAP_IDX_W'(1);
    end
  end

  // Counter update for warm and cool with saturation; others pass through.
  assign cur_val = $signed(ram_rdata);

  always_comb begin
    priority if (req_q == REQ_WARM) begin
      upd_val = (cur_val == CNT_MAX) ? cur_val : cur_val + COUNTER_W'(1);
    end else if (req_q == REQ_COOL) begin
      upd_val = (cur_val == CNT_MIN) ? cur_val : cur_val - COUNTER_W'(1);
    end else begin
      upd_val = cur_val;
    end
  end

  brhm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cur_val),
    .divisor_i  (cool_div_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Counter memory port selection.
  always_comb begin
    ram_we    = cmd_i.sweep_wr || cmd_i.apply || cmd_i.div_wr;
    ram_raddr = {slot_q, range_idx};
    if (cmd_i.sweep_wr) begin
      ram_waddr = {slot_q, sweep_cnt_q};
      ram_wdata = '0;
    end else begin
      ram_waddr = {slot_q, range_idx};
      ram_wdata = cmd_i.apply ? upd_val : div_quot;
    end
  end

  brhm_ram #(
    .WIDTH (COUNTER_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result value of the item in progress.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= '0;
    end else if (cmd_i.apply) begin
      value_q <= upd_val;
    end else if (cmd_i.div_wr) begin
      value_q <= div_quot;
    end
  end

  // Output register: holds a beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_value_q  <= value_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign counter_value_o = out_value_q;

  // Status toward the controller.
  always_comb begin
    flags_o.unused     = req_q > REQ_READ;
    flags_o.system     = key_q[ID_W-1:0] < first_rel_q;
    flags_o.clear      = req_q == REQ_CLEAR;
    flags_o.read       = req_q == REQ_READ;
    flags_o.div        = req_q == REQ_DIV;
    flags_o.oom        = {1'b0, blk_q} >= MAP_BLOCKS;
    flags_o.hit        = |hit_vec;
    flags_o.free       = ~&slot_valid_q;
    flags_o.sweep_last = sweep_cnt_q == MAP_IDX_W'(MAP_ENTRIES - 1);
    flags_o.div_zero   = cool_div_q == '0;
    flags_o.div_done   = div_done;
    flags_o.out_free   = !out_valid_q || !out_stall_i;
  end

`ifndef SYNTHESIS
  // A key lives in at most one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(hit_vec))
    else $error("relation key found in more than one slot");
  // Counters are only zeroed or updated in a slot that is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep_wr || cmd_i.apply || cmd_i.div_wr) |-> slot_valid_q[slot_q])
    else $error("counter write to a free slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/brhm_ctrl.sv =====
`default_nettype none

module brhm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire brhm_pkg::flags_t  flags_i,
  output brhm_pkg::cmd_t         cmd_o
);
  import brhm_pkg::*;

  state_e  state_q, state_d;
  status_e status_q, status_d;

  // Next state and result status.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d  = S_RESP;
        status_d = ST_OK;
        priority if (flags_i.unused) begin
          status_d = ST_OK;
        end else if (flags_i.system) begin
          status_d = ST_SYSTEM;
        end else if (flags_i.clear) begin
          if (flags_i.hit || flags_i.free) begin
            state_d = S_SWEEP;
          end else begin
            status_d = ST_FULL;
          end
        end else if (flags_i.oom) begin
          status_d = ST_OUT_OF_MAP;
        end else if (flags_i.read) begin
          if (flags_i.hit) begin
            state_d = S_READ;
          end else begin
            status_d = ST_ABSENT;
          end
        end else if (flags_i.hit) begin
          state_d = S_READ;
        end else if (flags_i.free) begin
          state_d = S_SWEEP;
        end else begin
          status_d = ST_FULL;
        end
      end
      S_SWEEP: begin
        if (flags_i.sweep_last) begin
          state_d = flags_i.clear ? S_RESP : S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        state_d = (flags_i.div && !flags_i.div_zero) ? S_DIV : S_RESP;
      end
      S_DIV: begin
        if (flags_i.div_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (flags_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_DECODE: begin
        cmd_o.pick  = 1'b1;
        cmd_o.alloc = !flags_i.unused && !flags_i.system && !flags_i.hit && flags_i.free &&
                      (flags_i.clear || (!flags_i.oom && !flags_i.read));
      end
      S_SWEEP:  cmd_o.sweep_wr = 1'b1;
      S_READ:   cmd_o.load = 1'b0;
      S_UPDATE: begin
        cmd_o.div_start = flags_i.div && !flags_i.div_zero;
        cmd_o.apply     = !(flags_i.div && !flags_i.div_zero);
      end
      S_DIV:    cmd_o.div_wr = flags_i.div_done;
      S_RESP:   cmd_o.emit = flags_i.out_free;
      default:  cmd_o.load = 1'b0;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

`ifndef SYNTHESIS
  // A slot is only taken for a relation that has none and when one is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.alloc |-> (flags_i.free && !flags_i.hit))
    else $error("slot allocated without need or room");
  // A result beat is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.emit |-> flags_i.out_free)
    else $error("result beat overwrites a pending beat");
  // Each accepted item leaves exactly one result before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after a result");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/block_range_heat_map.sv =====
`default_nettype none

// Heat counters over block ranges for up to REL_SLOTS relations.
// Input channel (in_valid_i / in_stall_o) carries one request beat: type,
// three-part relation key and block number. Result channel (out_valid_o /
// out_stall_i) returns exactly one beat per request: status and counter.
// Requests are handled one at a time; in_stall_o is high while one is busy.
// Steps from acceptance to result valid, for a known relation:
//   warm, cool, read: decode, counter read, update, then the result beat.
//   divide: as above, plus the bit-serial divider (32 steps) after the update.
//   skipped, out-of-map, absent or full: decode, then the result beat.
// First touch of a relation and every clear add a zeroing sweep of the
// MAP_ENTRIES (1024) entries of that slot's region of the counter memory,
// one write per cycle through its single write port.
// The output register lets a new request be accepted while a result beat
// waits; under a long receiver stall the next result holds the block busy.
// Reset empties the slot table and restores the configuration registers;
// the counter memory needs no clearing since a slot is zeroed on allocation.
// The user must make configuration writes (cfg_we_i) only while the block is idle; the block does not enforce this.
module block_range_heat_map (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [brhm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [brhm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic        [brhm_pkg::REQ_W-1:0]      req_type_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       tablespace_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       database_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       relation_id_i,
  input  wire logic        [brhm_pkg::ID_W-1:0]       block_number_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic             [brhm_pkg::STATUS_W-1:0]   status_o,
  output logic signed      [brhm_pkg::COUNTER_W-1:0]  counter_value_o
);
  import brhm_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // Sequencer for the request steps.
  brhm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // Slot table, counter memory, divider and output register.
  brhm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .tablespace_id_i (tablespace_id_i),
    .database_id_i   (database_id_i),
    .relation_id_i   (relation_id_i),
    .block_number_i  (block_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .counter_value_o (counter_value_o),
    .cmd_i           (cmd),
    .flags_o         (flags)
  );

endmodule

`default_nettype wire
